[sv/pocr_pkg.sv]
// ----------------------------------------------------------------------------
// pocr_pkg
// Shared types and constants of the order count derivation and reorder block.
// ----------------------------------------------------------------------------
package pocr_pkg;

  // NAL unit type codes
  localparam logic [4:0] NAL_RADL       = 5'd2;
  localparam logic [4:0] NAL_RASL       = 5'd3;
  localparam logic [4:0] NAL_IDR_W_RADL = 5'd7;
  localparam logic [4:0] NAL_CRA        = 5'd9;
  localparam logic [4:0] NAL_GDR        = 5'd10;
  localparam logic [4:0] NAL_IRAP_RSV   = 5'd11;

  localparam int unsigned LSB_W  = 16;
  localparam logic [4:0]  LG_MIN = 5'd4;
  localparam logic [4:0]  LG_MAX = 5'd16;
  localparam logic [4:0]  LG_RST = 5'd8;

  typedef struct packed {
    logic [4:0]  nal_type;
    logic [2:0]  temporal_id_plus1;
    logic        non_ref_pic;
    logic [15:0] poc_lsb;
    logic        msb_cycle_present;
    logic [27:0] msb_cycle_value;
    logic [7:0]  recovery_count;
  } pocr_unit_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } pocr_cell_ctrl_t;

  typedef struct packed {
    logic update;
    logic clear;
  } pocr_derive_ctrl_t;

endpackage

[sv/pocr_if.sv]
// ----------------------------------------------------------------------------
// pocr channel interfaces
// Valid/ready channels for access units, results and the configuration write.
// ----------------------------------------------------------------------------
interface pocr_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [4:0]  nal_type;
  logic [2:0]  temporal_id_plus1;
  logic        non_ref_pic;
  logic [15:0] poc_lsb;
  logic        msb_cycle_present;
  logic [27:0] msb_cycle_value;
  logic [7:0]  recovery_count;

  modport source (
    output valid, kind, nal_type, temporal_id_plus1, non_ref_pic, poc_lsb,
           msb_cycle_present, msb_cycle_value, recovery_count,
    input  ready
  );
  modport sink (
    input  valid, kind, nal_type, temporal_id_plus1, non_ref_pic, poc_lsb,
           msb_cycle_present, msb_cycle_value, recovery_count,
    output ready
  );
endinterface

interface pocr_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        unit_index;
  logic [31:0]        disp_number;
  logic signed [31:0] order_count;
  logic               last;

  modport source (
    output valid, unit_index, disp_number, order_count, last,
    input  ready
  );
  modport sink (
    input  valid, unit_index, disp_number, order_count, last,
    output ready
  );
endinterface

interface pocr_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] log2_max_poc_lsb;

  modport source (output valid, log2_max_poc_lsb, input ready);
  modport sink (input valid, log2_max_poc_lsb, output ready);
endinterface

[sv/poc_derive_and_segment_reorder.sv]
// ----------------------------------------------------------------------------
// poc_derive_and_segment_reorder
// Picture order count derivation with per-segment presentation reordering.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   takes one access unit (or an end-of-stream marker) per item.
//   out_o  delivers the buffered units of a segment, sorted by order count
//          (ties by arrival), numbered from zero; last marks a run's end.
//   cfg_i  writes log2_max_poc_lsb, always ready; the user writes it only while
//          idle, which the block itself does not enforce.
// Timing: one item at a time. A unit that closes no segment is accepted,
//   derived and sorted into the cell row before the next accept. A flush
//   pops the buffered units one by one from the head cell. An end-of-stream
//   marker flushes the buffered units, if there are any.
//   IRAP/GDR units and a full row of SEG_DEPTH cells trigger a flush before
//   the new unit is stored; end of stream flushes, then clears all counters.
// Reset: row empty, counters zero, log2_max_poc_lsb = 8; ready as soon as
//   reset is released.
// Stall: a result holds on out_o until taken; the row shifts only on a
//   completed output handshake, and in_i stays not ready meanwhile.
// ----------------------------------------------------------------------------
module poc_derive_and_segment_reorder #(
  parameter int unsigned SEG_DEPTH   = 32,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pocr_in_if.sink    in_i,
  pocr_out_if.source out_o,
  pocr_cfg_if.sink   cfg_i
);
  import pocr_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CALC   = 4'b0010,
    S_FLUSH  = 4'b0100,
    S_INSERT = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [4:0]        lg_cfg_q, lg_q, lg_clamp;
  pocr_unit_t        unit_q;
  logic              eos_q, eos_d;
  logic [CW-1:0]     poc_q, poc;
  logic              seg_start;
  logic [31:0]       unit_cnt_q, unit_cnt_d;
  logic [31:0]       next_num_q, next_num_d;
  logic              in_acc, out_acc;
  pocr_cell_ctrl_t   cell_ctrl;
  pocr_derive_ctrl_t der_ctrl;
  logic [CW+31:0]    count_ext;

  logic [SEG_DEPTH-1:0] valid_vec, disp_vec;
  logic [CW-1:0]        count_arr [SEG_DEPTH];
  logic [31:0]          index_arr [SEG_DEPTH];
  logic                 left_valid [SEG_DEPTH];
  logic [CW-1:0]        left_count [SEG_DEPTH];
  logic [31:0]          left_index [SEG_DEPTH];
  logic                 left_disp  [SEG_DEPTH];
  logic                 right_valid [SEG_DEPTH];
  logic [CW-1:0]        right_count [SEG_DEPTH];
  logic [31:0]          right_index [SEG_DEPTH];

  // configuration register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_cfg_q <= LG_RST;
    end else if (cfg_i.valid) begin
      lg_cfg_q <= cfg_i.log2_max_poc_lsb;
    end
  end

  always_comb begin
    if (lg_cfg_q < LG_MIN) begin
      lg_clamp = LG_MIN;
    end else if (lg_cfg_q > LG_MAX) begin
      lg_clamp = LG_MAX;
    end else begin
      lg_clamp = lg_cfg_q;
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign out_o.valid = (state_q == S_FLUSH) && valid_vec[0];
  assign out_acc     = out_o.valid && out_o.ready;
  assign count_ext   = {32'd0, count_arr[0]};
  assign out_o.unit_index  = index_arr[0];
  assign out_o.disp_number = next_num_q;
  assign out_o.order_count = count_ext[31:0];
  assign out_o.last        = !valid_vec[1];

  pocr_derive #(
    .COUNT_WIDTH(CW)
  ) u_derive (
    .clk_i,
    .rst_ni,
    .ctrl_i      (der_ctrl),
    .unit_i      (unit_q),
    .lg_i        (lg_q),
    .poc_o       (poc),
    .seg_start_o (seg_start)
  );

  // sequencer
  always_comb begin
    state_d         = state_q;
    eos_d           = eos_q;
    unit_cnt_d      = unit_cnt_q;
    next_num_d      = next_num_q;
    cell_ctrl       = '0;
    der_ctrl        = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          eos_d   = in_i.kind;
          state_d = in_i.kind ? S_FLUSH : S_CALC;
        end
      end
      S_CALC: begin
        der_ctrl.update = 1'b1;
        if ((seg_start && valid_vec[0]) || valid_vec[SEG_DEPTH-1]) begin
          state_d = S_FLUSH;
        end else begin
          state_d = S_INSERT;
        end
      end
      S_FLUSH: begin
        if (out_acc) begin
          cell_ctrl.pop = 1'b1;
          next_num_d    = next_num_q + 32'd1;
        end
        if (!valid_vec[0] || (out_acc && !valid_vec[1])) begin
          if (eos_q) begin
            der_ctrl.clear = 1'b1;
            unit_cnt_d     = '0;
            next_num_d     = '0;
            state_d        = S_IDLE;
          end else begin
            state_d = S_INSERT;
          end
        end
      end
      S_INSERT: begin
        cell_ctrl.insert = 1'b1;
        unit_cnt_d       = unit_cnt_q + 32'd1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      eos_q      <= 1'b0;
      unit_cnt_q <= '0;
      next_num_q <= '0;
    end else begin
      state_q    <= state_d;
      eos_q      <= eos_d;
      unit_cnt_q <= unit_cnt_d;
      next_num_q <= next_num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      unit_q.nal_type          <= in_i.nal_type;
      unit_q.temporal_id_plus1 <= in_i.temporal_id_plus1;
      unit_q.non_ref_pic       <= in_i.non_ref_pic;
      unit_q.poc_lsb           <= in_i.poc_lsb;
      unit_q.msb_cycle_present <= in_i.msb_cycle_present;
      unit_q.msb_cycle_value   <= in_i.msb_cycle_value;
      unit_q.recovery_count    <= in_i.recovery_count;
      lg_q                     <= lg_clamp;
    end
    if (state_q == S_CALC) begin
      poc_q <= poc;
    end
  end

  // row of sorted cells, head at index 0
  for (genvar g = 0; g < SEG_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_valid[g] = 1'b0;
      assign left_count[g] = '0;
      assign left_index[g] = '0;
      assign left_disp[g]  = 1'b0;
    end else begin : g_body
      assign left_valid[g] = valid_vec[g-1];
      assign left_count[g] = count_arr[g-1];
      assign left_index[g] = index_arr[g-1];
      assign left_disp[g]  = disp_vec[g-1];
    end
    if (g == SEG_DEPTH - 1) begin : g_tail
      assign right_valid[g] = 1'b0;
      assign right_count[g] = '0;
      assign right_index[g] = '0;
    end else begin : g_next
      assign right_valid[g] = valid_vec[g+1];
      assign right_count[g] = count_arr[g+1];
      assign right_index[g] = index_arr[g+1];
    end

    pocr_cell #(
      .COUNT_WIDTH(CW)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i        (cell_ctrl),
      .new_count_i   (poc_q),
      .new_index_i   (unit_cnt_q),
      .left_valid_i  (left_valid[g]),
      .left_count_i  (left_count[g]),
      .left_index_i  (left_index[g]),
      .left_disp_i   (left_disp[g]),
      .right_valid_i (right_valid[g]),
      .right_count_i (right_count[g]),
      .right_index_i (right_index[g]),
      .valid_o       (valid_vec[g]),
      .count_o       (count_arr[g]),
      .index_o       (index_arr[g]),
      .disp_o        (disp_vec[g])
    );
  end

`ifndef NO_ASSERTIONS
  logic [SEG_DEPTH-2:0] sorted_ok;
  for (genvar g = 0; g < SEG_DEPTH - 1; g++) begin : g_chk
    assign sorted_ok[g] = !valid_vec[g+1] ||
                          !($signed(count_arr[g+1]) < $signed(count_arr[g]));
  end

  // occupied cells form a prefix of the row
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + SEG_DEPTH'(1)) & valid_vec) == '0)
    else $error("cell row has a gap");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &sorted_ok)
    else $error("cell row out of order");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INSERT |-> !valid_vec[SEG_DEPTH-1])
    else $error("insert into full row");

  a_number_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !(eos_q && !valid_vec[1]) |=> next_num_q == $past(next_num_q) + 32'd1)
    else $error("presentation number did not advance");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input ready while flushing");
`endif

endmodule

[sv/pocr_derive.sv]
// ----------------------------------------------------------------------------
// pocr_derive
// Picture order count derivation; holds the previous reference count.
// ----------------------------------------------------------------------------
module pocr_derive #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pocr_pkg::pocr_derive_ctrl_t ctrl_i,
  input  pocr_pkg::pocr_unit_t       unit_i,
  input  logic [4:0]                 lg_i,
  output logic [COUNT_WIDTH-1:0]     poc_o,
  output logic                       seg_start_o
);
  import pocr_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;

  logic [CW-1:0]    prev_q, prev_d;
  logic             have_q, have_d;
  logic [LSB_W:0]   max_lsb;
  logic [LSB_W-1:0] mask, half, lsb, ref_lsb;
  logic [CW-1:0]    ref_msb, msb, msb_exp;
  logic             clvss, ref_pic, wrap_up, wrap_dn;

  always_comb begin
    max_lsb  = (LSB_W+1)'(1) << lg_i;
    mask     = LSB_W'(max_lsb - (LSB_W+1)'(1));
    half     = LSB_W'(max_lsb >> 1);
    lsb      = unit_i.poc_lsb & mask;
    ref_lsb  = prev_q[LSB_W-1:0] & mask;
    ref_msb  = prev_q - CW'(ref_lsb);
    msb_exp  = CW'(unit_i.msb_cycle_value) << lg_i;
    wrap_up  = (lsb < ref_lsb) && ((ref_lsb - lsb) >= half);
    wrap_dn  = (lsb > ref_lsb) && ((lsb - ref_lsb) > half);

    clvss = (unit_i.nal_type >= NAL_IDR_W_RADL && unit_i.nal_type <= NAL_CRA) ||
            unit_i.nal_type == NAL_IRAP_RSV ||
            (unit_i.nal_type == NAL_GDR && unit_i.recovery_count == 8'd0);

    if (unit_i.msb_cycle_present) begin
      msb = msb_exp;
    end else if (clvss || !have_q) begin
      msb = '0;
    end else if (wrap_up) begin
      msb = ref_msb + CW'(max_lsb);
    end else if (wrap_dn) begin
      msb = ref_msb - CW'(max_lsb);
    end else begin
      msb = ref_msb;
    end
    poc_o = msb + CW'(lsb);

    // temporal id 0, reference picture, not a leading picture
    ref_pic = unit_i.temporal_id_plus1 == 3'd1 && !unit_i.non_ref_pic &&
              unit_i.nal_type != NAL_RADL && unit_i.nal_type != NAL_RASL;
    seg_start_o = unit_i.nal_type >= NAL_IDR_W_RADL &&
                  unit_i.nal_type <= NAL_IRAP_RSV;

    prev_d = prev_q;
    have_d = have_q;
    if (ctrl_i.clear) begin
      prev_d = '0;
      have_d = 1'b0;
    end else if (ctrl_i.update && ref_pic) begin
      prev_d = poc_o;
      have_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  // only read while have_q is set
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
  end

endmodule

[sv/pocr_cell.sv]
// ----------------------------------------------------------------------------
// pocr_cell
// One slot of the sorted segment buffer: sorted insert, shift left on pop.
// ----------------------------------------------------------------------------
module pocr_cell #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pocr_pkg::pocr_cell_ctrl_t ctrl_i,
  input  logic [COUNT_WIDTH-1:0]   new_count_i,
  input  logic [31:0]              new_index_i,
  input  logic                     left_valid_i,
  input  logic [COUNT_WIDTH-1:0]   left_count_i,
  input  logic [31:0]              left_index_i,
  input  logic                     left_disp_i,
  input  logic                     right_valid_i,
  input  logic [COUNT_WIDTH-1:0]   right_count_i,
  input  logic [31:0]              right_index_i,
  output logic                     valid_o,
  output logic [COUNT_WIDTH-1:0]   count_o,
  output logic [31:0]              index_o,
  output logic                     disp_o
);
  import pocr_pkg::*;

  logic                   valid_q, valid_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [31:0]            index_q, index_d;

  // empty slots sort after everything; ties keep arrival order
  assign disp_o = !valid_q || ($signed(new_count_i) < $signed(count_q));

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    index_d = index_q;
    if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      count_d = right_count_i;
      index_d = right_index_i;
    end else if (ctrl_i.insert && disp_o) begin
      if (left_disp_i) begin
        valid_d = left_valid_i;
        count_d = left_count_i;
        index_d = left_index_i;
      end else begin
        valid_d = 1'b1;
        count_d = new_count_i;
        index_d = new_index_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    index_q <= index_d;
  end

  assign valid_o = valid_q;
  assign count_o = count_q;
  assign index_o = index_q;

endmodule
